// File: rtl/core/stfb_pkg.sv
// package: constants, types and the seven-segment character table
`timescale 1ns / 1ps
package stfb_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int POS_W = $clog2(DIGIT_COUNT + 1);
  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int SEQ_W = $clog2(DIGIT_COUNT + 2);

  localparam int CMD_W = 2;
  localparam int CHAR_W = 8;
  localparam int BYTE_W = 8;
  localparam int BRIGHT_W = 3;

  localparam logic [BYTE_W-1:0] CMD_AUTO_INC = 8'h40;
  localparam logic [BYTE_W-1:0] CMD_ADDR_ZERO = 8'hC0;
  localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON = 8'h88;
  localparam int DOT_BIT = 7;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_TEXT   = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_BRIGHT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef logic [BYTE_W-1:0] seg_t;

  function automatic seg_t seg_encode(input logic [CHAR_W-1:0] ch);
    seg_t s;
    unique case (ch)
      "0":      s = 8'h3F;
      "1":      s = 8'h06;
      "2":      s = 8'h5B;
      "3":      s = 8'h4F;
      "4":      s = 8'h66;
      "5":      s = 8'h6D;
      "6":      s = 8'h7D;
      "7":      s = 8'h07;
      "8":      s = 8'h7F;
      "9":      s = 8'h6F;
      "-":      s = 8'h40;
      "A", "a": s = 8'h77;
      "B", "b": s = 8'h7C;
      "C":      s = 8'h39;
      "c":      s = 8'h58;
      "D", "d": s = 8'h5E;
      "E", "e": s = 8'h79;
      "F", "f": s = 8'h71;
      "G", "g": s = 8'h3D;
      "H":      s = 8'h76;
      "h":      s = 8'h74;
      "I", "i": s = 8'h30;
      "J", "j": s = 8'h1E;
      "L", "l": s = 8'h38;
      "N":      s = 8'h37;
      "n":      s = 8'h54;
      "O":      s = 8'h3F;
      "o":      s = 8'h5C;
      "P", "p": s = 8'h73;
      "R", "r": s = 8'h50;
      "S", "s": s = 8'h6D;
      "T", "t": s = 8'h78;
      "U":      s = 8'h3E;
      "u":      s = 8'h1C;
      "Y", "y": s = 8'h6E;
      default:  s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/stfb_ifs.sv
// channel interfaces: text/command input, byte output, brightness write
`timescale 1ns / 1ps
interface stfb_in_if import stfb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;
  modport source (output valid, cmd, char_code, last_char, input ready);
  modport sink (input valid, cmd, char_code, last_char, output ready);
endinterface

interface stfb_out_if import stfb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              begin_transfer;
  logic [BYTE_W-1:0] data_byte;
  logic              end_transfer;
  logic              last;
  modport source (output valid, begin_transfer, data_byte, end_transfer, last, input ready);
  modport sink (input valid, begin_transfer, data_byte, end_transfer, last, output ready);
endinterface

interface stfb_cfg_if import stfb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BRIGHT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/core/seven_segment_text_frame_builder.sv
// top level: text to seven-segment frame builder with byte output sequencer
`timescale 1ns / 1ps
// Takes one command or text character per input transfer into an input register,
// encodes it combinationally and updates the digit store. A character marked
// last_char, or a clear command, loads a six-byte display frame (0x40 alone, then
// 0xC0 and the four digit bytes) into the output buffer; a brightness command
// loads the single byte 0x88 | brightness. Items that give no bytes go through at
// one per cycle. An item that gives bytes waits only until the output buffer has
// shown its final byte; it is taken in the cycle that byte is accepted, so frames
// follow back to back. The one-byte-wide output port gives one byte per cycle
// while out_chan.ready is high. Brightness writes are taken in any cycle.
module seven_segment_text_frame_builder import stfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  stfb_in_if.sink    in_chan,
  stfb_out_if.source out_chan,
  stfb_cfg_if.sink   cfg_chan
);

  // input register
  logic              item_vld_r;
  cmd_t              cmd_r;
  logic [CHAR_W-1:0] char_r;
  logic              fin_r;

  // digit store
  seg_t              digits_r [DIGIT_COUNT];
  seg_t              digits_upd [DIGIT_COUNT];
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_upd;

  // output buffer
  logic              buf_vld_r;
  logic              buf_bright_r;
  logic [SEQ_W-1:0]  seq_r;
  seg_t              frame_r [DIGIT_COUNT];

  logic [BRIGHT_W-1:0] bright_r;

  logic is_dot;
  logic is_text;
  logic frame_done;
  logic needs_out;
  logic out_xfer;
  logic buf_free;
  logic item_go;
  logic [SEQ_W-1:0] digit_sel;

  assign cfg_chan.ready = 1'b1;

  assign is_dot  = (char_r == ".") || (char_r == ":");
  assign is_text = (cmd_r == CMD_TEXT);
  assign needs_out = (is_text && fin_r) || (cmd_r == CMD_CLEAR) || (cmd_r == CMD_BRIGHT);

  assign out_xfer = out_chan.valid && out_chan.ready;
  assign buf_free = !buf_vld_r || (out_xfer && out_chan.last);
  assign item_go  = item_vld_r && (!needs_out || buf_free);
  assign in_chan.ready = !item_vld_r || item_go;

  // apply one text character to the store
  always_comb begin
    pos_upd = pos_r;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      digits_upd[i] = digits_r[i];
    end
    if (is_text && (pos_r < POS_W'(DIGIT_COUNT))) begin
      if (is_dot) begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          if (pos_r == POS_W'(i + 1)) begin
            digits_upd[i][DOT_BIT] = 1'b1;
          end
        end
      end else begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          if (pos_r == POS_W'(i)) begin
            digits_upd[i] = seg_encode(char_r);
          end
        end
        pos_upd = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      item_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      cmd_r  <= cmd_t'(in_chan.cmd);
      char_r <= in_chan.char_code;
      fin_r  <= in_chan.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= BRIGHT_RESET;
    end else if (cfg_chan.valid) begin
      bright_r <= cfg_chan.data;
    end
  end

  assign frame_done = (is_text && fin_r) || (cmd_r == CMD_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digits_r[i] <= '0;
      end
    end else if (item_go) begin
      if (frame_done) begin
        pos_r <= '0;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          digits_r[i] <= '0;
        end
      end else if (is_text) begin
        pos_r <= pos_upd;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          digits_r[i] <= digits_upd[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
    end else if (item_go && needs_out) begin
      buf_vld_r <= 1'b1;
    end else if (out_xfer && out_chan.last) begin
      buf_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go && needs_out) begin
      seq_r        <= '0;
      buf_bright_r <= (cmd_r == CMD_BRIGHT);
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        frame_r[i] <= (cmd_r == CMD_CLEAR) ? '0 : digits_upd[i];
      end
    end else if (out_xfer) begin
      seq_r <= seq_r + SEQ_W'(1);
    end
  end

  // byte order within a frame: auto-increment, address zero, then the digits
  assign digit_sel = seq_r - SEQ_W'(2);
  assign out_chan.valid = buf_vld_r;

  always_comb begin
    if (buf_bright_r) begin
      out_chan.begin_transfer = 1'b1;
      out_chan.data_byte      = CMD_DISPLAY_ON | BYTE_W'(bright_r);
      out_chan.end_transfer   = 1'b1;
      out_chan.last           = 1'b1;
    end else if (seq_r == SEQ_W'(0)) begin
      out_chan.begin_transfer = 1'b1;
      out_chan.data_byte      = CMD_AUTO_INC;
      out_chan.end_transfer   = 1'b1;
      out_chan.last           = 1'b0;
    end else if (seq_r == SEQ_W'(1)) begin
      out_chan.begin_transfer = 1'b1;
      out_chan.data_byte      = CMD_ADDR_ZERO;
      out_chan.end_transfer   = 1'b0;
      out_chan.last           = 1'b0;
    end else begin
      out_chan.begin_transfer = 1'b0;
      out_chan.data_byte      = frame_r[digit_sel[IDX_W-1:0]];
      out_chan.end_transfer   = (seq_r == SEQ_W'(DIGIT_COUNT + 1));
      out_chan.last           = (seq_r == SEQ_W'(DIGIT_COUNT + 1));
    end
  end

endmodule
